/* design/wcns_pkg.sv */
// wcns_pkg: sizes, field widths, the weight table, controller states and the
// command/status bundles shared by the nearest-codebook search block.
// No dependencies.
package wcns_pkg;

    localparam int ENTRIES    = 32;
    localparam int COEFFS     = 12;
    localparam int COEF_WIDTH = 16;

    // request and result field widths
    localparam int OP_W     = 1;
    localparam int ENTRY_W  = 5;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 16;
    localparam int SYM_W    = 6;
    localparam int DIST_W   = 48;

    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_FRAME = 1'b1;

    localparam int TOTAL      = ENTRIES * COEFFS;
    localparam int ADDR_W     = $clog2(TOTAL);
    localparam int ROW_W      = $clog2(ENTRIES);
    localparam int COEF_IDX_W = (COEFFS > 1) ? $clog2(COEFFS) : 1;

    localparam int MAG_W    = COEF_WIDTH + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int WEIGHT_W = 6;
    localparam int TERM_W   = SQ_W + WEIGHT_W;
    localparam int ACC_W    = ((TERM_W > DIST_W) ? TERM_W : DIST_W) + 1;

    localparam int NUM_WEIGHTS = 12;
    localparam logic [WEIGHT_W-1:0] WEIGHTS [NUM_WEIGHTS] = '{
        6'd1, 6'd3, 6'd7, 6'd13, 6'd19, 6'd22,
        6'd25, 6'd33, 6'd42, 6'd50, 6'd56, 6'd61
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic                  cb_we;
        logic                  fv_we;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic [COEF_IDX_W-1:0] rd_coef;
        logic                  rd_last_coef;
        logic                  rd_last_row;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_status;

    // positions past the table reuse the last weight
    function automatic logic [WEIGHT_W-1:0] weight_at(input logic [COEF_IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        if (32'(idx) < NUM_WEIGHTS) begin
            w = WEIGHTS[32'(idx)];
        end else begin
            w = WEIGHTS[NUM_WEIGHTS-1];
        end
        return w;
    endfunction

endpackage

/* design/wcns_ctrl.sv */
// wcns_ctrl: request decode, scan sequencer and busy flag.
// Uses wcns_pkg; drives the datapath through t_dp_cmd.
module wcns_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [wcns_pkg::OP_W-1:0]      i_op,
    input  logic [wcns_pkg::ENTRY_W-1:0]   i_entry,
    input  logic [wcns_pkg::POS_W-1:0]     i_coef_index,
    input  wcns_pkg::t_dp_status           i_status,
    output wcns_pkg::t_dp_cmd              o_cmd,
    output logic                           busy
);

    wcns_pkg::t_state                      r_state, n_state;
    logic [wcns_pkg::ADDR_W-1:0]           r_addr, n_addr;
    logic [wcns_pkg::COEF_IDX_W-1:0]       r_coef, n_coef;
    logic                                  pos_ok;
    logic                                  entry_ok;
    logic                                  last_coef;
    logic                                  last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcns_pkg::ST_IDLE;
            r_addr  <= '0;
            r_coef  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_coef  <= n_coef;
        end
    end

    assign pos_ok    = 32'(i_coef_index) < wcns_pkg::COEFFS;
    assign entry_ok  = 32'(i_entry) < wcns_pkg::ENTRIES;
    assign last_coef = r_coef == wcns_pkg::COEF_IDX_W'(wcns_pkg::COEFFS - 1);
    assign last_row  = r_addr == wcns_pkg::ADDR_W'(wcns_pkg::TOTAL - 1);

    always_comb begin
        n_state             = r_state;
        n_addr              = r_addr;
        n_coef              = r_coef;
        o_cmd.cb_we         = 1'b0;
        o_cmd.fv_we         = 1'b0;
        o_cmd.rd_en         = 1'b0;
        o_cmd.rd_addr       = r_addr;
        o_cmd.rd_coef       = r_coef;
        o_cmd.rd_last_coef  = last_coef;
        o_cmd.rd_last_row   = last_row;
        busy                = 1'b1;
        case (r_state)
            wcns_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start && pos_ok) begin
                    if (i_op == wcns_pkg::OP_LOAD) begin
                        o_cmd.cb_we = entry_ok;
                    end else begin
                        o_cmd.fv_we = 1'b1;
                        // last position completes the frame: start the scan
                        if (32'(i_coef_index) == wcns_pkg::COEFFS - 1) begin
                            n_state = wcns_pkg::ST_SCAN;
                            n_addr  = '0;
                            n_coef  = '0;
                        end
                    end
                end
            end
            wcns_pkg::ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + 1'b1;
                n_coef      = last_coef ? '0 : r_coef + 1'b1;
                if (last_row) begin
                    n_state = wcns_pkg::ST_DRAIN;
                end
            end
            wcns_pkg::ST_DRAIN: begin
                if (i_status.scan_done) begin
                    n_state = wcns_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wcns_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/wcns_dp.sv */
// wcns_dp: codebook memory, frame registers, distance pipeline and
// running minimum. Uses wcns_pkg; controlled by wcns_ctrl via t_dp_cmd.
module wcns_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wcns_pkg::t_dp_cmd                     i_cmd,
    input  logic [wcns_pkg::ENTRY_W-1:0]          i_entry,
    input  logic [wcns_pkg::POS_W-1:0]            i_coef_index,
    input  logic signed [wcns_pkg::VALUE_W-1:0]   i_value,
    output wcns_pkg::t_dp_status                  o_status,
    output logic                                  o_done,
    output logic [wcns_pkg::SYM_W-1:0]            o_symbol,
    output logic [wcns_pkg::DIST_W-1:0]           o_min_distance
);

    localparam int CW = wcns_pkg::COEF_WIDTH;

    logic signed [CW-1:0]                  mem [wcns_pkg::TOTAL];
    logic signed [CW-1:0]                  r_frame [wcns_pkg::COEFFS];

    logic signed [CW-1:0]                  coef_in;
    logic [wcns_pkg::ADDR_W-1:0]           wr_addr;
    logic [wcns_pkg::COEF_IDX_W-1:0]       wr_pos;

    // stage 1: memory and frame read
    logic signed [CW-1:0]                  r_cb_q, r_fv_q;
    logic                                  r_s1_valid, r_s1_lc, r_s1_lr;
    logic [wcns_pkg::COEF_IDX_W-1:0]       r_s1_coef;
    // stage 2: magnitude of difference
    logic signed [CW:0]                    diff;
    logic [wcns_pkg::MAG_W-1:0]            r_mag;
    logic                                  r_s2_valid, r_s2_lc, r_s2_lr;
    logic [wcns_pkg::COEF_IDX_W-1:0]       r_s2_coef;
    // stage 3: square
    logic [wcns_pkg::SQ_W-1:0]             r_sq;
    logic                                  r_s3_valid, r_s3_lc, r_s3_lr;
    logic [wcns_pkg::COEF_IDX_W-1:0]       r_s3_coef;
    // stage 4: weighted term
    logic [wcns_pkg::TERM_W-1:0]           r_term;
    logic                                  r_s4_valid, r_s4_lc, r_s4_lr;
    // stage 5: row accumulation
    logic [wcns_pkg::ACC_W-1:0]            sum_wide;
    logic [wcns_pkg::DIST_W-1:0]           sum_sat;
    logic [wcns_pkg::DIST_W-1:0]           r_acc;
    logic [wcns_pkg::DIST_W-1:0]           r_row_sum;
    logic                                  r_s5_valid, r_s5_last;
    // stage 6: running minimum
    logic [wcns_pkg::DIST_W-1:0]           r_best;
    logic [wcns_pkg::ROW_W-1:0]            r_best_row, r_row_cnt;
    logic                                  take_row;
    logic [wcns_pkg::DIST_W-1:0]           fin_dist;
    logic [wcns_pkg::ROW_W-1:0]            fin_row;
    logic [wcns_pkg::ROW_W:0]              sym_wide;
    logic                                  r_done;
    logic [wcns_pkg::SYM_W-1:0]            r_symbol;
    logic [wcns_pkg::DIST_W-1:0]           r_min_distance;

    assign coef_in = CW'($unsigned(i_value));
    assign wr_pos  = wcns_pkg::COEF_IDX_W'(i_coef_index);
    assign wr_addr = wcns_pkg::ADDR_W'(32'(i_entry) * wcns_pkg::COEFFS + 32'(i_coef_index));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cb_we) begin
            mem[wr_addr] <= coef_in;
        end
        if (i_cmd.rd_en) begin
            r_cb_q <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fv_we) begin
            r_frame[wr_pos] <= coef_in;
        end
    end

    assign diff = {r_fv_q[CW-1], r_fv_q} - {r_cb_q[CW-1], r_cb_q};

    assign sum_wide = wcns_pkg::ACC_W'(r_acc) + wcns_pkg::ACC_W'(r_term);
    assign sum_sat  = (sum_wide[wcns_pkg::ACC_W-1:wcns_pkg::DIST_W] != '0) ? '1
                    : sum_wide[wcns_pkg::DIST_W-1:0];

    // first row always wins; later rows only when strictly smaller
    assign take_row = (r_row_cnt == '0) || (r_row_sum < r_best);
    assign fin_dist = take_row ? r_row_sum : r_best;
    assign fin_row  = take_row ? r_row_cnt : r_best_row;
    assign sym_wide = {1'b0, fin_row} + 1'b1;

    // payload stages
    always_ff @(posedge i_clk) begin
        r_fv_q    <= r_frame[i_cmd.rd_coef];
        r_s1_coef <= i_cmd.rd_coef;
        r_s1_lc   <= i_cmd.rd_last_coef;
        r_s1_lr   <= i_cmd.rd_last_row;

        r_mag     <= diff[CW] ? wcns_pkg::MAG_W'(-diff) : wcns_pkg::MAG_W'(diff);
        r_s2_coef <= r_s1_coef;
        r_s2_lc   <= r_s1_lc;
        r_s2_lr   <= r_s1_lr;

        r_sq      <= wcns_pkg::SQ_W'(r_mag) * wcns_pkg::SQ_W'(r_mag);
        r_s3_coef <= r_s2_coef;
        r_s3_lc   <= r_s2_lc;
        r_s3_lr   <= r_s2_lr;

        r_term    <= wcns_pkg::TERM_W'(r_sq) * wcns_pkg::TERM_W'(wcns_pkg::weight_at(r_s3_coef));
        r_s4_lc   <= r_s3_lc;
        r_s4_lr   <= r_s3_lr;

        if (r_s4_valid && r_s4_lc) begin
            r_row_sum <= sum_sat;
        end
        if (r_s5_valid) begin
            r_symbol       <= wcns_pkg::SYM_W'(sym_wide);
            r_min_distance <= fin_dist;
            if (take_row) begin
                r_best     <= r_row_sum;
                r_best_row <= r_row_cnt;
            end
        end
    end

    // control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s5_last  <= 1'b0;
            r_acc      <= '0;
            r_row_cnt  <= '0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid && r_s4_lc;
            r_s5_last  <= r_s4_valid && r_s4_lc && r_s4_lr;
            if (r_s4_valid) begin
                r_acc <= r_s4_lc ? '0 : sum_sat;
            end
            if (r_s5_valid) begin
                r_row_cnt <= r_s5_last ? '0 : r_row_cnt + 1'b1;
            end
            r_done <= r_s5_valid && r_s5_last;
        end
    end

    assign o_status.scan_done = r_s5_valid && r_s5_last;
    assign o_done             = r_done;
    assign o_symbol           = r_symbol;
    assign o_min_distance     = r_min_distance;

endmodule

/* design/weighted_codebook_nearest_search.sv */
// weighted_codebook_nearest_search: top level, controller plus datapath.
// Depends on wcns_pkg, wcns_ctrl and wcns_dp.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// i_op selects a codebook load (i_entry, i_coef_index, i_value written to
// the codebook) or a frame coefficient (i_coef_index, i_value written to
// the frame vector). Requests with a position past the last coefficient,
// or loads to a row past the last, are dropped.
// Loads and frame coefficients other than the last complete without a scan
// and busy stays low. The frame coefficient at the last position starts a
// scan: the codebook is read one coefficient per cycle through the single
// memory read port, then the distance pipeline and minimum tracking finish.
// busy stays high through the scan until o_done rises, so a completing frame
// holds off the next request until its result appears.
// o_done is high for exactly one cycle with o_symbol (one-based nearest
// row, lowest row on ties) and o_min_distance; busy is already low in that
// cycle. The receiver cannot stall, so the result must be taken then.
// Reset (synchronous, active low) returns to idle and drops any scan;
// codebook and frame contents are undefined until written.
module weighted_codebook_nearest_search (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [wcns_pkg::OP_W-1:0]             i_op,
    input  logic [wcns_pkg::ENTRY_W-1:0]          i_entry,
    input  logic [wcns_pkg::POS_W-1:0]            i_coef_index,
    input  logic signed [wcns_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_done,
    output logic [wcns_pkg::SYM_W-1:0]            o_symbol,
    output logic [wcns_pkg::DIST_W-1:0]           o_min_distance
);

    wcns_pkg::t_dp_cmd     cmd;
    wcns_pkg::t_dp_status  status;

    wcns_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_op         (i_op),
        .i_entry      (i_entry),
        .i_coef_index (i_coef_index),
        .i_status     (status),
        .o_cmd        (cmd),
        .busy         (busy)
    );

    wcns_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_entry        (i_entry),
        .i_coef_index   (i_coef_index),
        .i_value        (i_value),
        .o_status       (status),
        .o_done         (o_done),
        .o_symbol       (o_symbol),
        .o_min_distance (o_min_distance)
    );

endmodule

/* design/wcns_checker.sv */
// wcns_checker: port-level assertions for the search block, bound to the
// top level. Depends on wcns_pkg and weighted_codebook_nearest_search.
module wcns_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [wcns_pkg::OP_W-1:0]             i_op,
    input  logic [wcns_pkg::POS_W-1:0]            i_coef_index,
    input  logic                                  o_done,
    input  logic [wcns_pkg::SYM_W-1:0]            o_symbol,
    input  logic [wcns_pkg::DIST_W-1:0]           o_min_distance
);

    logic acc_req;
    logic completes;

    assign acc_req   = start && !busy;
    assign completes = (i_op == wcns_pkg::OP_FRAME) &&
                       (32'(i_coef_index) == wcns_pkg::COEFFS - 1);

    // a completed frame always starts a scan
    a_scan_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_req && completes |=> busy)
        else $error("completing frame request did not start a scan");

    // any other request finishes in its own cycle
    a_short_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_req && !completes |=> !busy && !o_done)
        else $error("non-completing request made the block busy or gave a result");

    // the result appears exactly when the scan ends
    a_done_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy ##1 !busy |-> o_done)
        else $error("scan ended without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result outside the end of a scan");

    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown({o_symbol, o_min_distance}))
        else $error("result carries unknown bits");

endmodule

bind weighted_codebook_nearest_search wcns_checker u_wcns_checker (.*);

/* sim/weighted_codebook_nearest_search_test.sv */
// weighted_codebook_nearest_search_test: self-checking bench for the nearest codebook
// search; a scoreboard class tracks codebook and frame contents and predicts each symbol
// and distance. Depends on wcns_pkg and weighted_codebook_nearest_search.
module weighted_codebook_nearest_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = wcns_pkg::ENTRIES;
    localparam int COEFFS      = wcns_pkg::COEFFS;
    localparam int OP_W        = wcns_pkg::OP_W;
    localparam int ENTRY_W     = wcns_pkg::ENTRY_W;
    localparam int POS_W       = wcns_pkg::POS_W;
    localparam int VALUE_W     = wcns_pkg::VALUE_W;
    localparam int SYM_W       = wcns_pkg::SYM_W;
    localparam int DIST_W      = wcns_pkg::DIST_W;

    localparam int ITEM_TARGET = 1600;
    localparam int QUIET_FROM  = 1400;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SCAN_CYCLES = ENTRIES * COEFFS + 64;
    localparam int VALUE_MAX   = 32767;
    localparam int VALUE_MIN   = -32768;
    localparam int REPORT_MAX  = 10;
    localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;
    localparam longint unsigned TOKHURA_W [12] = '{1, 3, 7, 13, 19, 22, 25, 33, 42, 50, 56, 61};

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [DIST_W-1:0] distance;
    } t_match;

    class tokhura_scoreboard;
        int     codebook [ENTRIES][COEFFS];
        int     frame [COEFFS];
        t_match expected_matches [$];
        int     mismatches;
        int     results_checked;
        int     tied_results;

        function longint unsigned tokhura_weight(int i);
            return TOKHURA_W[(i < 12) ? i : 11];
        endfunction

        function longint unsigned row_distance(int r);
            longint unsigned sum;
            longint unsigned term;
            longint d;
            sum = 0;
            for (int i = 0; i < COEFFS; i++) begin
                d = longint'(frame[i]) - longint'(codebook[r][i]);
                if (d < 0) begin
                    d = -d;
                end
                term = longint'(d) * longint'(d) * tokhura_weight(i);
                if (term > DIST_SAT - sum) begin
                    sum = DIST_SAT;
                end else begin
                    sum = sum + term;
                end
            end
            return sum;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ENTRY_W-1:0] entry,
                                   logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] value);
            t_match          m;
            longint unsigned best_d;
            longint unsigned d;
            int              best;
            bit              tie;
            if (int'(pos) >= COEFFS) begin
                return;
            end
            if (op == wcns_pkg::OP_LOAD) begin
                if (int'(entry) < ENTRIES) begin
                    codebook[entry][pos] = int'(value);
                end
                return;
            end
            frame[pos] = int'(value);
            if (int'(pos) != COEFFS - 1) begin
                return;
            end
            best = 0;
            best_d = row_distance(0);
            tie = 1'b0;
            for (int r = 1; r < ENTRIES; r++) begin
                d = row_distance(r);
                if (d < best_d) begin
                    best_d = d;
                    best = r;
                    tie = 1'b0;
                end else if (d == best_d) begin
                    tie = 1'b1;
                end
            end
            if (tie) begin
                tied_results++;
            end
            m.symbol = SYM_W'(best + 1);
            m.distance = best_d[DIST_W-1:0];
            expected_matches.push_back(m);
        endfunction

        function void check_result(logic [SYM_W-1:0] symbol, logic [DIST_W-1:0] distance);
            t_match m;
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: symbol %0d distance %0d", symbol, distance);
                end
                return;
            end
            m = expected_matches.pop_front();
            results_checked++;
            if (symbol !== m.symbol || distance !== m.distance) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result %0d: symbol %0d expected %0d, distance %0d expected %0d",
                             results_checked, symbol, m.symbol, distance, m.distance);
                end
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [OP_W-1:0]           i_op = wcns_pkg::OP_LOAD;
    logic [ENTRY_W-1:0]        i_entry = '0;
    logic [POS_W-1:0]          i_coef_index = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_done;
    logic [SYM_W-1:0]          o_symbol;
    logic [DIST_W-1:0]         o_min_distance;

    tokhura_scoreboard scoreboard = new();
    int requests_taken = 0;
    int requests_ignored = 0;
    int cycle_count = 0;
    int idle_percent = 0;

    weighted_codebook_nearest_search i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_entry        (i_entry),
        .i_coef_index   (i_coef_index),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_symbol       (o_symbol),
        .o_min_distance (o_min_distance)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // results are checked before the request of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                scoreboard.check_result(o_symbol, o_min_distance);
            end
            if (start && !busy) begin
                scoreboard.note_request(i_op, i_entry, i_coef_index, i_value);
                if (int'(i_coef_index) < COEFFS) begin
                    requests_taken++;
                end else begin
                    requests_ignored++;
                end
            end
        end
    end

    function automatic int random_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return int'($urandom_range(0, 15)) - 8;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // spread below zero means a value unrelated to the base
    function automatic int near_value(int base, int spread);
        int v;
        if (spread < 0) begin
            return random_value();
        end
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > VALUE_MAX) begin
            v = VALUE_MAX;
        end
        if (v < VALUE_MIN) begin
            v = VALUE_MIN;
        end
        return v;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input int entry, input int pos,
                                input int value);
        int gap;
        i_op <= op;
        i_entry <= ENTRY_W'(entry);
        i_coef_index <= POS_W'(pos);
        i_value <= VALUE_W'(value);
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (idle_percent > 0 && int'($urandom_range(0, 99)) < idle_percent) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic fill_row(input int row);
        for (int i = 0; i < COEFFS; i++) begin
            send_request(wcns_pkg::OP_LOAD, row, i, random_value());
        end
    endtask

    // writes count of the leading positions (in order or shuffled) near a codebook row, then the last one
    task automatic send_frame(input int row, input int spread, input int count);
        int order [COEFFS-1];
        int j;
        int t;
        for (int i = 0; i < COEFFS - 1; i++) begin
            order[i] = i;
        end
        if ($urandom_range(0, 1) == 1) begin
            for (int i = COEFFS - 2; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        for (int i = 0; i < count; i++) begin
            send_request(wcns_pkg::OP_FRAME, $urandom_range(0, ENTRIES - 1), order[i],
                         near_value(scoreboard.codebook[row][order[i]], spread));
        end
        send_request(wcns_pkg::OP_FRAME, $urandom_range(0, ENTRIES - 1), COEFFS - 1,
                     near_value(scoreboard.codebook[row][COEFFS-1], spread));
    endtask

    function automatic int pick_spread();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 3;
            2: return 200;
            3: return 4000;
            default: return -1;
        endcase
    endfunction

    initial begin
        int src;
        int dst;
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_percent = 30;

        // every codebook word holds the most negative value before any scan
        for (int r = 0; r < ENTRIES; r++) begin
            for (int i = 0; i < COEFFS; i++) begin
                send_request(wcns_pkg::OP_LOAD, r, i, VALUE_MIN);
            end
        end
        // frame at the top of the range: all rows tie at the largest distance
        for (int i = 0; i < COEFFS; i++) begin
            send_request(wcns_pkg::OP_FRAME, $urandom_range(0, ENTRIES - 1), i, VALUE_MAX);
        end
        // positions past the last coefficient are dropped for both operations
        send_request(wcns_pkg::OP_LOAD, 3, COEFFS, VALUE_MAX);
        send_request(wcns_pkg::OP_LOAD, ENTRIES - 1, 15, -1);
        send_request(wcns_pkg::OP_FRAME, 0, 13, 0);
        send_request(wcns_pkg::OP_FRAME, ENTRIES - 1, 14, VALUE_MIN);
        // only the last row matches at the last position
        send_request(wcns_pkg::OP_LOAD, ENTRIES - 1, COEFFS - 1, VALUE_MAX);
        send_request(wcns_pkg::OP_FRAME, 0, COEFFS - 1, VALUE_MAX);
        // tie between two rows, the lower one wins
        send_request(wcns_pkg::OP_LOAD, 7, COEFFS - 1, VALUE_MAX);
        send_request(wcns_pkg::OP_FRAME, 0, COEFFS - 1, VALUE_MAX);
        send_request(wcns_pkg::OP_FRAME, 0, 0, VALUE_MIN);
        send_request(wcns_pkg::OP_FRAME, 0, COEFFS - 1, VALUE_MAX);

        for (int r = 0; r < ENTRIES; r++) begin
            fill_row(r);
        end
        while (requests_taken + requests_ignored < ITEM_TARGET) begin
            if (requests_taken + requests_ignored >= QUIET_FROM) begin
                idle_percent = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: idle_percent = 0;
                    1: idle_percent = 20;
                    2: idle_percent = 50;
                    default: idle_percent = 80;
                endcase
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    send_frame($urandom_range(0, ENTRIES - 1), pick_spread(), COEFFS - 1);
                end
                9, 10, 11: begin
                    send_frame($urandom_range(0, ENTRIES - 1), pick_spread(), $urandom_range(0, 4));
                end
                12, 13, 14: begin
                    n = $urandom_range(1, COEFFS);
                    src = $urandom_range(0, ENTRIES - 1);
                    for (int i = 0; i < n; i++) begin
                        send_request(wcns_pkg::OP_LOAD, src, $urandom_range(0, COEFFS - 1),
                                     random_value());
                    end
                end
                15: begin
                    // duplicate a row so a frame on or close to it can hit a tie
                    src = $urandom_range(0, ENTRIES - 1);
                    dst = $urandom_range(0, ENTRIES - 1);
                    for (int i = 0; i < COEFFS; i++) begin
                        send_request(wcns_pkg::OP_LOAD, dst, i, scoreboard.codebook[src][i]);
                    end
                    send_frame(src, $urandom_range(0, 1), COEFFS - 1);
                end
                16, 17: begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        send_request($urandom_range(0, 1) ? wcns_pkg::OP_FRAME : wcns_pkg::OP_LOAD,
                                     $urandom_range(0, ENTRIES - 1),
                                     $urandom_range(COEFFS, 15), random_value());
                    end
                end
                18: begin
                    send_request(wcns_pkg::OP_FRAME, $urandom_range(0, ENTRIES - 1),
                                 $urandom_range(0, COEFFS - 2), random_value());
                end
                default: begin
                    fill_row($urandom_range(0, ENTRIES - 1));
                end
            endcase
        end

        start <= 1'b0;
        while (scoreboard.expected_matches.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SCAN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests plus %0d dropped ones, %0d nearest-row results checked",
                 requests_taken, requests_ignored, scoreboard.results_checked);
        $display("%0d results were decided by a tie on distance, %0d mismatches",
                 scoreboard.tied_results, scoreboard.mismatches);
        if (scoreboard.mismatches == 0 && scoreboard.expected_matches.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
design/wcns_pkg.sv
design/wcns_ctrl.sv
design/wcns_dp.sv
design/weighted_codebook_nearest_search.sv
design/wcns_checker.sv
sim/weighted_codebook_nearest_search_test.sv
